[hw/rtl/mcg_pkg.sv]
// Package for the macroblock command generator: field widths, command codes,
// the descriptor record passed from front end to back end. No dependencies.
package mcg_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int QDEPTH    = 4;
	localparam int QAW       = 2;

	localparam logic [1:0] OP_PUT  = 2'd0;
	localparam logic [1:0] OP_AVG  = 2'd1;
	localparam logic [1:0] OP_COPY = 2'd2;
	localparam logic [1:0] OP_ADD  = 2'd3;

	localparam logic [1:0] PL_Y  = 2'd0;
	localparam logic [1:0] PL_CR = 2'd1;
	localparam logic [1:0] PL_CB = 2'd2;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_INTRA = 2'd1;
	localparam logic [1:0] KIND_ERR   = 2'd2;
	localparam logic [1:0] KIND_INTER = 2'd3;

	// classified macroblock, position already resolved
	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  flags;
		logic [25:0] fv0;
		logic [25:0] fv1;
		logic [25:0] bv0;
		logic [25:0] bv1;
		logic [3:0]  fsel;
		logic [5:0]  cbp;
		logic [12:0] w;
		logic [11:0] x;
		logic [15:0] y;
	} mb_desc_t;

	typedef struct packed {
		logic [1:0]  op_kind;
		logic [1:0]  plane;
		logic [1:0]  half_pel;
		logic        ref_select;
		logic [27:0] src_offset;
		logic [26:0] dst_offset;
		logic [13:0] line_stride;
		logic [4:0]  row_count;
		logic [2:0]  coef_block;
		logic        last;
		logic        error;
	} cmd_t;

endpackage

[hw/rtl/mcg_front.sv]
// Front end: accepts descriptors, divides the address by macroblocks per row
// one quotient bit a cycle, classifies the macroblock. Uses mcg_pkg.
module mcg_front import mcg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [12:0] picture_width,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] mb_address,
	input  logic [5:0]  mb_flags,
	input  logic [25:0] fwd_vec_first,
	input  logic [25:0] fwd_vec_second,
	input  logic [25:0] bwd_vec_first,
	input  logic [25:0] bwd_vec_second,
	input  logic [3:0]  field_selects,
	input  logic [5:0]  block_pattern,
	output logic        d_valid,
	input  logic        d_ready,
	output mb_desc_t    d_data
);

	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q, quo_q;
	logic [8:0]  mbw_q;
	mb_desc_t    hold_q;
	logic [12:0] wsat;
	logic [8:0]  mbw;
	logic [16:0] trial;
	logic [16:0] sh;
	logic [1:0]  kind;

	assign wsat = (picture_width > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : picture_width;
	assign mbw  = (wsat[12:4] == 9'd0) ? 9'd1 : wsat[12:4];
	assign in_ready = !busy_q && !done_q;

	always_comb begin
		if (mb_flags[0])
			kind = KIND_INTRA;
		else if (mb_flags[3] && !mb_flags[1] && !mb_flags[2])
			kind = KIND_ERR;
		else if (mb_flags[1] || mb_flags[2] || mb_flags[3])
			kind = KIND_INTER;
		else
			kind = KIND_NONE;
	end

	assign sh    = {rem_q, quo_q[15]};
	assign trial = sh - {8'd0, mbw_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (done_q && d_ready) begin
				done_q <= 1'b0;
			end
		end
	end

	// restoring division: remainder shifts in dividend bits from the top
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hold_q.kind  <= kind;
			hold_q.flags <= mb_flags;
			hold_q.fv0   <= fwd_vec_first;
			hold_q.fv1   <= fwd_vec_second;
			hold_q.bv0   <= bwd_vec_first;
			hold_q.bv1   <= bwd_vec_second;
			hold_q.fsel  <= field_selects;
			hold_q.cbp   <= block_pattern;
			hold_q.w     <= wsat;
			hold_q.x     <= '0;
			hold_q.y     <= '0;
			mbw_q        <= mbw;
			rem_q        <= '0;
			quo_q        <= mb_address;
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= sh[15:0];
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	always_comb begin
		d_data   = hold_q;
		d_data.x = rem_q[11:0];
		d_data.y = quo_q;
	end
	assign d_valid = done_q;

endmodule

[hw/rtl/mcg_queue.sv]
// Short descriptor queue between front and back ends. Uses mcg_pkg.
module mcg_queue import mcg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	output logic     wr_ready,
	input  mb_desc_t wr_data,
	output logic     rd_valid,
	input  logic     rd_ready,
	output mb_desc_t rd_data
);

	mb_desc_t   mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (QAW+1)'(QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(wr) - (QAW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

[hw/rtl/mcg_back.sv]
// Back end: steps through the command run of one macroblock into an output
// register, one command a cycle while it is not stalled. Uses mcg_pkg.
module mcg_back import mcg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     d_valid,
	output logic     d_ready,
	input  mb_desc_t d_data,
	output logic     c_valid,
	input  logic     c_ready,
	output cmd_t     c_data
);

	// slot 0..5: fwd pred0 Y,Cr,Cb / pred1; 6..11 bwd; 12..17 residual blocks
	logic [4:0]  slot_q;
	logic        act_q;
	logic        ov_q;
	cmd_t        out_q;
	logic [17:0] need;
	logic [17:0] rest;
	logic [4:0]  slot;
	logic        adv, take, fin;
	cmd_t        cmd;
	logic        frame, ild, bwd_dir, second, chroma, is_cr, is_cb;
	logic [2:0]  blk;
	logic [25:0] vec;
	logic        fs;
	logic signed [23:0] vx, vy, xi, yi, xc, yc, xp, yp;
	logic signed [27:0] pitch, cp, src_y, src_c;
	logic [27:0] w28, dy, dc, lstep, dd;

	assign w28   = {15'd0, d_data.w};
	assign frame = d_data.flags[4];
	assign ild   = d_data.flags[5];
	assign dy    = 28'(d_data.x) * 28'd16 + 28'(d_data.y) * w28 * 28'd16;
	assign dc    = 28'(d_data.x) * 28'd8 + 28'(d_data.y) * w28 * 28'd4;
	assign lstep = ild ? w28 : w28 * 28'd8;

	always_comb begin
		need = '0;
		case (d_data.kind)
			KIND_INTRA: need[17:12] = 6'h3f;
			KIND_ERR:   need[12] = 1'b1;
			KIND_INTER: begin
				if (d_data.flags[1]) need[5:0]  = frame ? 6'h07 : 6'h3f;
				if (d_data.flags[2]) need[11:6] = frame ? 6'h07 : 6'h3f;
				if (d_data.flags[3])
					for (int i = 0; i < 6; i++) need[12+i] = d_data.cbp[5-i];
			end
			default: need = '0;
		endcase
		// first wanted slot at or beyond the current one
		slot = 5'd0;
		for (int i = 17; i >= 0; i--)
			if (need[i] && (!act_q || 5'(i) >= slot_q)) slot = 5'(i);
		rest = '0;
		for (int i = 0; i < 18; i++) rest[i] = need[i] && 5'(i) > slot;
	end

	assign fin  = (rest == '0);
	assign adv  = d_valid && (need != '0) && (!ov_q || c_ready);
	assign take = d_valid && ((need == '0) || (adv && fin));
	assign d_ready = take;

	always_comb begin
		bwd_dir = slot >= 5'd6;
		second  = (slot >= 5'd3 && slot < 5'd6) || (slot >= 5'd9 && slot < 5'd12);
		is_cr   = slot inside {5'd1, 5'd4, 5'd7, 5'd10};
		is_cb   = slot inside {5'd2, 5'd5, 5'd8, 5'd11};
		chroma  = is_cr || is_cb;
		vec = bwd_dir ? (second ? d_data.bv1 : d_data.bv0)
		              : (second ? d_data.fv1 : d_data.fv0);
		// frame motion ignores the field selects
		fs  = !frame && d_data.fsel[{bwd_dir, second}];
		vx  = 24'(signed'(vec[12:0]));
		vy  = 24'(signed'(vec[25:13]));
		xp  = vx + signed'(24'(d_data.x) * 24'd32);
		yp  = frame ? vy + signed'(24'(d_data.y) * 24'd32)
		            : (vy >>> 1) + signed'(24'(d_data.y) * 24'd16);
		xi  = xp >>> 1;
		yi  = yp >>> 1;
		xc  = xi >>> 1;
		yc  = yi >>> 1;
		pitch = frame ? signed'(w28) : signed'(w28 * 28'd2);
		cp    = pitch >>> 1;
		src_y = 28'(xi) + 28'(yi) * pitch + (fs ? (pitch >>> 1) : 28'd0);
		src_c = 28'(xc) + 28'(yc) * cp + (fs ? (cp >>> 1) : 28'd0);
		blk = 3'(slot - 5'd12);
		dd  = '0;
		cmd = '0;
		cmd.last = fin;
		if (slot < 5'd12) begin
			cmd.op_kind = (bwd_dir && d_data.flags[1]) ? OP_AVG : OP_PUT;
			cmd.ref_select = bwd_dir;
			cmd.plane = chroma ? (is_cr ? PL_CR : PL_CB) : PL_Y;
			cmd.half_pel = chroma ? {yi[0], xi[0]} : {yp[0], xp[0]};
			cmd.src_offset = chroma ? src_c : src_y;
			cmd.dst_offset = chroma ? 27'(dc + (second ? w28 >> 1 : 28'd0))
			                        : 27'(dy + (second ? w28 : 28'd0));
			cmd.line_stride = 14'(chroma ? cp : pitch);
			cmd.row_count = frame ? (chroma ? 5'd8 : 5'd16) : (chroma ? 5'd4 : 5'd8);
		end else if (d_data.kind == KIND_ERR) begin
			cmd.error = 1'b1;
		end else begin
			cmd.op_kind = (d_data.kind == KIND_INTRA) ? OP_COPY : OP_ADD;
			cmd.coef_block = blk;
			cmd.row_count = 5'd8;
			case (blk)
				3'd0: dd = dy;
				3'd1: dd = dy + 28'd8;
				3'd2: dd = dy + lstep;
				3'd3: dd = dy + lstep + 28'd8;
				default: dd = dc;
			endcase
			cmd.dst_offset = 27'(dd);
			cmd.plane = (blk == 3'd4) ? PL_CR : ((blk == 3'd5) ? PL_CB : PL_Y);
			cmd.line_stride = (blk >= 3'd4) ? 14'(w28 >> 1)
			                                : 14'(ild ? w28 * 28'd2 : w28);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			slot_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (adv) begin
				ov_q <= 1'b1;
			end else if (c_ready) begin
				ov_q <= 1'b0;
			end
			if (take) begin
				act_q <= 1'b0;
			end else if (adv) begin
				act_q  <= 1'b1;
				slot_q <= slot + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) out_q <= cmd;
	end

	assign c_valid = ov_q;
	assign c_data  = out_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !c_ready |=> ov_q && $stable(out_q))
		else $error("command changed while stalled");
	a_take_adv: assert property (@(posedge clk) disable iff (!arst_n)
		take && (need != '0) |-> adv)
		else $error("descriptor dropped without its last command");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cmd.error |-> cmd.last)
		else $error("error command not last");

endmodule

[hw/rtl/mc_macroblock_command_generator_unit.sv]
// Top level of the macroblock command generator: APB register, front end,
// descriptor queue, back end. Uses mcg_pkg, mcg_front, mcg_queue, mcg_back.
//
// Usage: write picture_width (address 0) over APB while idle; it resets to 720.
// Descriptors enter on s_axis; tdata packs mb_address, mb_flags, the four
// vectors, field_selects and block_pattern. Commands leave on m_axis, one per
// accepted beat, tlast on the final command of a macroblock.
// The front end divides the address bit-serially and takes no new
// descriptor until the queue has accepted the last; the back end emits one
// command per cycle while m_axis is not stalled, up to 18 per macroblock, so
// the output channel usually sets the pace. A four-entry queue lets the front
// end run ahead.
// Reset clears all control state; the queue and output register empty.
// When m_axis_tready is low the pending command holds and the back end
// stalls; the front end keeps filling the queue until it is full.
module mc_macroblock_command_generator_unit import mcg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [0:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// mb_address, mb_flags, fwd_vec_first, fwd_vec_second, bwd_vec_first,
	// bwd_vec_second, field_selects, block_pattern (bits 135:0)
	input  logic [135:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// op_kind, plane, half_pel, ref_select, src_offset, dst_offset,
	// line_stride, row_count, coef_block (bits 83:0), zero pad
	output logic [87:0]  m_axis_tdata,
	output logic         m_axis_tlast,
	// error
	output logic         m_axis_tuser
);

	logic [12:0] width_q;
	logic        fv, fr, qv, qr;
	mb_desc_t    fd, qd;
	cmd_t        c;

	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {19'd0, width_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) width_q <= 13'd720;
		else if (psel && penable && pwrite && paddr == 1'b0) width_q <= pwdata[12:0];
	end

	mcg_front u_front (
		.clk, .arst_n, .picture_width(width_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.mb_address(s_axis_tdata[15:0]), .mb_flags(s_axis_tdata[21:16]),
		.fwd_vec_first(s_axis_tdata[47:22]), .fwd_vec_second(s_axis_tdata[73:48]),
		.bwd_vec_first(s_axis_tdata[99:74]), .bwd_vec_second(s_axis_tdata[125:100]),
		.field_selects(s_axis_tdata[129:126]), .block_pattern(s_axis_tdata[135:130]),
		.d_valid(fv), .d_ready(fr), .d_data(fd)
	);

	mcg_queue u_queue (
		.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fd),
		.rd_valid(qv), .rd_ready(qr), .rd_data(qd)
	);

	mcg_back u_back (
		.clk, .arst_n, .d_valid(qv), .d_ready(qr), .d_data(qd),
		.c_valid(m_axis_tvalid), .c_ready(m_axis_tready), .c_data(c)
	);

	assign m_axis_tdata = {4'd0, c.coef_block, c.row_count, c.line_stride,
		c.dst_offset, c.src_offset, c.ref_select, c.half_pel, c.plane, c.op_kind};
	assign m_axis_tlast = c.last;
	assign m_axis_tuser = c.error;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for the macroblock command generator: drives macroblock descriptors,
// predicts the block command run of each one and checks every command. Uses mcg_pkg.
module tb_top;
	import mcg_pkg::*;

	typedef struct {
		logic [15:0] addr;
		logic [5:0]  flags;
		logic [25:0] fv0, fv1, bv0, bv1;
		logic [3:0]  fsel;
		logic [5:0]  cbp;
	} mb_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [0:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [135:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [87:0] m_axis_tdata;
	logic m_axis_tlast;
	logic m_axis_tuser;

	mc_macroblock_command_generator_unit DUT (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	mb_t pending_mbs[$];
	cmd_t expected_cmds[$];
	logic [12:0] pic_width = 13'd720;
	int errors = 0;
	int unsigned cycles = 0;
	bit stim_done = 0;

	function automatic longint fhalf(longint v);
		return (v - (v & 1)) / 2;
	endfunction

	function automatic longint sx13(logic [12:0] r);
		return longint'($signed(r));
	endfunction

	function automatic void push_cmd(logic [1:0] k, logic [1:0] pl, int hp, bit rs,
			longint src, longint dst, longint stride, int rows, int coef, bit err);
		cmd_t c;
		c.op_kind = k;
		c.plane = pl;
		c.half_pel = hp[1:0];
		c.ref_select = rs;
		c.src_offset = src[27:0];
		c.dst_offset = dst[26:0];
		c.line_stride = stride[13:0];
		c.row_count = rows[4:0];
		c.coef_block = coef[2:0];
		c.last = 0;
		c.error = err;
		expected_cmds.push_back(c);
	endfunction

	function automatic void fetch_cmds(logic [1:0] k, bit rs, longint xp, longint yp,
			longint fs, longint dy, longint dc, longint pitch, longint h);
		longint xi, yi, xc, yc, cp, src;
		int hp;
		hp = int'(((yp & 1) << 1) | (xp & 1));
		xi = fhalf(xp);
		yi = fhalf(yp);
		src = xi + yi * pitch + fs * (pitch / 2);
		push_cmd(k, PL_Y, hp, rs, src, dy, pitch, int'(h), 0, 0);
		hp = int'(((yi & 1) << 1) | (xi & 1));
		xc = fhalf(xi);
		yc = fhalf(yi);
		cp = pitch / 2;
		src = xc + yc * cp + fs * (cp / 2);
		push_cmd(k, PL_CR, hp, rs, src, dc, cp, int'(h / 2), 0, 0);
		push_cmd(k, PL_CB, hp, rs, src, dc, cp, int'(h / 2), 0, 0);
	endfunction

	function automatic void motion_cmds(logic [1:0] k, bit rs, bit frame,
			logic [25:0] v0, logic [25:0] v1, bit fs0, bit fs1,
			longint x, longint y, longint w, longint dy, longint dc);
		if (frame) begin
			fetch_cmds(k, rs, sx13(v0[12:0]) + x * 32, sx13(v0[25:13]) + y * 32,
				0, dy, dc, w, 16);
		end else begin
			fetch_cmds(k, rs, sx13(v0[12:0]) + x * 32,
				fhalf(sx13(v0[25:13])) + y * 16, fs0, dy, dc, w * 2, 8);
			fetch_cmds(k, rs, sx13(v1[12:0]) + x * 32,
				fhalf(sx13(v1[25:13])) + y * 16, fs1, dy + w, dc + w / 2, w * 2, 8);
		end
	endfunction

	function automatic void predict_commands(mb_t m);
		longint w, mbw, x, y, dy, dc, pitch, lstep, cw;
		int first;
		bit intra, fwd, bwd, pat, frame, ildct;
		first = expected_cmds.size();
		{ildct, frame, pat, bwd, fwd, intra} = m.flags;
		w = pic_width;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		mbw = w / 16;
		if (mbw < 1) mbw = 1;
		y = longint'(m.addr) / mbw;
		x = longint'(m.addr) - mbw * y;
		pitch = ildct ? w * 2 : w;
		lstep = ildct ? w : w * 8;
		cw = w / 2;
		dy = x * 16 + y * w * 16;
		dc = x * 8 + y * w * 4;
		if (intra) begin
			push_cmd(OP_COPY, PL_Y, 0, 0, 0, dy, pitch, 8, 0, 0);
			push_cmd(OP_COPY, PL_Y, 0, 0, 0, dy + 8, pitch, 8, 1, 0);
			push_cmd(OP_COPY, PL_Y, 0, 0, 0, dy + lstep, pitch, 8, 2, 0);
			push_cmd(OP_COPY, PL_Y, 0, 0, 0, dy + lstep + 8, pitch, 8, 3, 0);
			push_cmd(OP_COPY, PL_CR, 0, 0, 0, dc, cw, 8, 4, 0);
			push_cmd(OP_COPY, PL_CB, 0, 0, 0, dc, cw, 8, 5, 0);
		end else if (pat && !fwd && !bwd) begin
			push_cmd(OP_PUT, PL_Y, 0, 0, 0, 0, 0, 0, 0, 1);
		end else begin
			if (fwd)
				motion_cmds(OP_PUT, 0, frame, m.fv0, m.fv1, m.fsel[0], m.fsel[1],
					x, y, w, dy, dc);
			if (bwd)
				motion_cmds(fwd ? OP_AVG : OP_PUT, 1, frame, m.bv0, m.bv1,
					m.fsel[2], m.fsel[3], x, y, w, dy, dc);
			if (pat) begin
				if (m.cbp[5]) push_cmd(OP_ADD, PL_Y, 0, 0, 0, dy, pitch, 8, 0, 0);
				if (m.cbp[4]) push_cmd(OP_ADD, PL_Y, 0, 0, 0, dy + 8, pitch, 8, 1, 0);
				if (m.cbp[3]) push_cmd(OP_ADD, PL_Y, 0, 0, 0, dy + lstep, pitch, 8, 2, 0);
				if (m.cbp[2])
					push_cmd(OP_ADD, PL_Y, 0, 0, 0, dy + lstep + 8, pitch, 8, 3, 0);
				if (m.cbp[1]) push_cmd(OP_ADD, PL_CR, 0, 0, 0, dc, cw, 8, 4, 0);
				if (m.cbp[0]) push_cmd(OP_ADD, PL_CB, 0, 0, 0, dc, cw, 8, 5, 0);
			end
		end
		if (expected_cmds.size() > first)
			expected_cmds[expected_cmds.size() - 1].last = 1;
	endfunction

	// driver: bursts with random gaps; predict on acceptance
	int gap = 0;
	int burst = 0;
	bit hold_off = 0;
	bit accepted = 0;
	mb_t cur;
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			predict_commands(cur);
			void'(pending_mbs.pop_front());
			accepted = 1;
		end
	end
	always @(negedge clk) begin
		// hold a request until it is taken
		if (!s_axis_tvalid || accepted) begin
			accepted = 0;
			if (gap > 0 || hold_off || pending_mbs.size() == 0 || !arst_n) begin
				if (gap > 0) gap <= gap - 1;
				s_axis_tvalid <= 0;
			end else begin
				cur = pending_mbs[0];
				s_axis_tdata <= {cur.cbp, cur.fsel, cur.bv1, cur.bv0, cur.fv1, cur.fv0,
					cur.flags, cur.addr};
				s_axis_tvalid <= 1;
				if (burst == 0) begin
					burst = $urandom_range(1, 12);
					gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
				end else begin
					burst = burst - 1;
				end
			end
		end
	end

	// receiver stall pattern: alternate stretches of steady and random ready
	int stall_phase = 0;
	always @(negedge clk) begin
		stall_phase <= (stall_phase + 1) % 300;
		if (stall_phase < 100) m_axis_tready <= 1;
		else if (stall_phase < 200) m_axis_tready <= ($urandom_range(0, 3) != 0);
		else m_axis_tready <= ($urandom_range(0, 3) == 0);
	end

	// monitor
	always @(posedge clk) begin
		cmd_t e, a;
		cycles <= cycles + 1;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			a.op_kind = m_axis_tdata[1:0];
			a.plane = m_axis_tdata[3:2];
			a.half_pel = m_axis_tdata[5:4];
			a.ref_select = m_axis_tdata[6];
			a.src_offset = m_axis_tdata[34:7];
			a.dst_offset = m_axis_tdata[61:35];
			a.line_stride = m_axis_tdata[75:62];
			a.row_count = m_axis_tdata[80:76];
			a.coef_block = m_axis_tdata[83:81];
			a.last = m_axis_tlast;
			a.error = m_axis_tuser;
			if (expected_cmds.size() == 0) begin
				$error("unexpected command %h", m_axis_tdata);
				errors++;
			end else begin
				e = expected_cmds.pop_front();
				if (a.op_kind !== e.op_kind) begin
					$error("op_kind exp %0d got %0d", e.op_kind, a.op_kind); errors++; end
				if (a.plane !== e.plane) begin
					$error("plane exp %0d got %0d", e.plane, a.plane); errors++; end
				if (a.half_pel !== e.half_pel) begin
					$error("half_pel exp %0d got %0d", e.half_pel, a.half_pel); errors++; end
				if (a.ref_select !== e.ref_select) begin
					$error("ref_select exp %0d got %0d", e.ref_select, a.ref_select);
					errors++;
				end
				if (a.src_offset !== e.src_offset) begin
					$error("src_offset exp %h got %h", e.src_offset, a.src_offset); errors++; end
				if (a.dst_offset !== e.dst_offset) begin
					$error("dst_offset exp %h got %h", e.dst_offset, a.dst_offset); errors++; end
				if (a.line_stride !== e.line_stride) begin
					$error("line_stride exp %0d got %0d", e.line_stride, a.line_stride);
					errors++;
				end
				if (a.row_count !== e.row_count) begin
					$error("row_count exp %0d got %0d", e.row_count, a.row_count); errors++; end
				if (a.coef_block !== e.coef_block) begin
					$error("coef_block exp %0d got %0d", e.coef_block, a.coef_block);
					errors++;
				end
				if (a.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, a.last); errors++; end
				if (a.error !== e.error) begin
					$error("error exp %0d got %0d", e.error, a.error); errors++; end
			end
		end
		if (cycles > 400000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [25:0] rand_vec();
		case ($urandom_range(0, 4))
			0: return {13'h1000, 13'h1000};
			1: return {13'h0fff, 13'h0fff};
			2: return {13'($urandom_range(0, 15) - 8), 13'($urandom_range(0, 15) - 8)};
			default: return 26'($urandom);
		endcase
	endfunction

	function automatic mb_t rand_mb();
		mb_t m;
		m.addr = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
		m.flags = 6'($urandom);
		if ($urandom_range(0, 3) != 0) m.flags[0] = 0;
		m.fv0 = rand_vec();
		m.fv1 = rand_vec();
		m.bv0 = rand_vec();
		m.bv1 = rand_vec();
		m.fsel = 4'($urandom);
		m.cbp = 6'($urandom);
		return m;
	endfunction

	task automatic apb_write(logic [12:0] val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= '0; pwdata <= {19'd0, val};
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		pic_width = val;
	endtask

	task automatic wait_drained();
		wait (pending_mbs.size() == 0 && !s_axis_tvalid);
		wait (expected_cmds.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic run_phase(logic [12:0] width, int count);
		mb_t m;
		wait_drained();
		apb_write(width);
		for (int i = 0; i < count; i++) begin
			m = rand_mb();
			pending_mbs.push_back(m);
			if (i == count / 2) begin
				// hold until every expected command has come
				wait (pending_mbs.size() == 0 && !s_axis_tvalid);
				hold_off = 1;
				wait (expected_cmds.size() == 0);
				hold_off = 0;
			end
		end
	endtask

	initial begin
		mb_t m;
		repeat (2) @(negedge clk);
		arst_n = 1;
		// directed: each kind of macroblock at default width
		for (int i = 0; i < 20; i++) begin
			m = rand_mb();
			case (i)
				0: m.flags = 6'h01;
				1: m.flags = 6'h21;
				2: m.flags = 6'h08;
				3: m.flags = 6'h00;
				4: m.flags = 6'h12;
				5: m.flags = 6'h02;
				6: m.flags = 6'h14;
				7: m.flags = 6'h1e;
				8: m.flags = 6'h0e;
				9: m.flags = 6'h2e;
				10: begin m.flags = 6'h3e; m.addr = 16'hffff; m.cbp = 6'h3f; end
				11: begin m.flags = 6'h0a; m.cbp = 6'h00; m.addr = 0; end
				12: begin m.flags = 6'h0e; m.fv0 = 26'h3ffffff; m.bv1 = 0; m.fsel = 4'hf; end
				13: begin m.flags = 6'h3f; m.addr = 16'hffff; end
				default: ;
			endcase
			pending_mbs.push_back(m);
		end
		run_phase(13'd16, 50);
		run_phase(13'd8191, 50);
		run_phase(13'd4096, 40);
		run_phase(13'd0, 30);
		run_phase(13'd100, 40);
		run_phase(13'd4112, 40);
		run_phase(13'd720, 80);
		wait_drained();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
